### hdl/bphtrk_pkg.sv
package bphtrk_pkg;

    // Button index width and count of tracked buttons
    localparam int BTN_W       = 1;
    localparam int NUM_BUTTONS = 2;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HOLD_TICKS_RST   = CNT_W'(5);
    localparam logic [CNT_W-1:0] REPEAT_TICKS_RST = CNT_W'(10);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 1'b1;

    // Item opcodes and pin levels
    localparam logic OP_PIN       = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic PIN_PRESSED  = 1'b0;

    typedef enum logic [1:0] {
        ST_UP   = 2'd0,
        ST_DOWN = 2'd1,
        ST_HOLD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        EV_DOWN       = 3'd0,
        EV_UP         = 3'd1,
        EV_RELEASE    = 3'd2,
        EV_HOLD       = 3'd3,
        EV_HOLD_CLICK = 3'd4
    } t_event;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             armed;
    } t_btn_state;

    typedef struct packed {
        logic    emit;
        t_event  ev;
        t_status status;
    } t_step_res;

endpackage

### hdl/bphtrk_step.sv
module bphtrk_step
    import bphtrk_pkg::*;
(
    input  logic             i_op,
    input  logic             i_pin_level,
    input  t_btn_state       i_cur,
    input  logic [CNT_W-1:0] i_hold_ticks,
    input  logic [CNT_W-1:0] i_repeat_ticks,
    output t_btn_state       o_next,
    output t_step_res        o_res
);

    // Update one button's state for a pin edge or a hold tick
    always_comb begin
        o_next       = i_cur;
        o_res.emit   = 1'b0;
        o_res.ev     = EV_DOWN;
        o_res.status = i_cur.status;

        if (i_op == OP_PIN) begin
            if (i_pin_level == PIN_PRESSED) begin
                // press: arm hold timing from zero
                o_next.status = ST_DOWN;
                o_next.count  = '0;
                o_next.armed  = 1'b1;
                o_res.emit    = 1'b1;
                o_res.ev      = EV_DOWN;
                o_res.status  = ST_DOWN;
            end else begin
                // release: short press reports up, after hold reports release
                o_next.status = ST_UP;
                if (i_cur.armed) begin
                    o_next.armed = 1'b0;
                    o_next.count = '0;
                end
                o_res.emit   = 1'b1;
                o_res.ev     = (i_cur.status == ST_DOWN) ? EV_UP : EV_RELEASE;
                o_res.status = ST_UP;
            end
        end else if (i_cur.armed) begin
            if (i_pin_level != PIN_PRESSED) begin
                // tick saw the pin up: drop tracking silently
                o_next.armed  = 1'b0;
                o_next.count  = '0;
                o_next.status = ST_UP;
            end else begin
                // hold wins over repeat on the same tick
                if (i_cur.count == i_hold_ticks) begin
                    o_next.status = ST_HOLD;
                    o_res.emit    = 1'b1;
                    o_res.ev      = EV_HOLD;
                    o_res.status  = ST_HOLD;
                end else if (i_cur.count > i_repeat_ticks) begin
                    o_res.emit    = 1'b1;
                    o_res.ev      = EV_HOLD_CLICK;
                end
                // advance the counter, saturating
                if (i_cur.count != CNT_MAX) begin
                    o_next.count = i_cur.count + CNT_W'(1);
                end
            end
        end
    end

endmodule

### hdl/button_press_hold_tracker_unit.sv
// Channel  | Handshake                  | Beat contents
// ---------+----------------------------+----------------------------------------
// input    | i_in_valid / o_in_ready    | i_op, i_button, i_pin_level
// result   | o_out_valid / i_out_ready  | o_button_out, o_event_res, o_status_now
// config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while results are taken; a beat passes the input register
// first, and its result is then written to the result register.
// The update runs between the input register and the result register, and the
// per-button state is written in the same cycle, so back-to-back beats chain.
// Synchronous active-low reset clears state to up, unarmed, counters zero.
// A stalled result holds the result register; items with no result still pass.
module button_press_hold_tracker_unit
    import bphtrk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [BTN_W-1:0]     i_button,
    input  logic                 i_pin_level,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BTN_W-1:0]     o_button_out,
    output logic [2:0]           o_event_res,
    output logic [1:0]           o_status_now,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    logic             r_in_valid;
    logic             r_op;
    logic [BTN_W-1:0] r_button;
    logic             r_pin_level;

    logic [CNT_W-1:0] r_hold_ticks;
    logic [CNT_W-1:0] r_repeat_ticks;

    t_btn_state       r_state [NUM_BUTTONS];

    logic             r_out_valid;
    logic [BTN_W-1:0] r_button_out;
    t_event           r_event;
    t_status          r_status;

    t_btn_state       w_cur;
    t_btn_state       n_state;
    t_step_res        w_res;
    logic             w_go;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks   <= HOLD_TICKS_RST;
            r_repeat_ticks <= REPEAT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data;
                REG_REPEAT_TICKS: r_repeat_ticks <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Process the held beat when the result slot is free or not needed
    assign w_go       = r_in_valid && (!w_res.emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op        <= i_op;
            r_button    <= i_button;
            r_pin_level <= i_pin_level;
        end
    end

    assign w_cur = r_state[r_button];

    bphtrk_step u_step (
        .i_op           (r_op),
        .i_pin_level    (r_pin_level),
        .i_cur          (w_cur),
        .i_hold_ticks   (r_hold_ticks),
        .i_repeat_ticks (r_repeat_ticks),
        .o_next         (n_state),
        .o_res          (w_res)
    );

    // Per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_state[b] <= '{status: ST_UP, count: '0, armed: 1'b0};
            end
        end else if (w_go) begin
            r_state[r_button] <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res.emit) begin
            r_button_out <= r_button;
            r_event      <= w_res.ev;
            r_status     <= w_res.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_button_out = r_button_out;
    assign o_event_res  = 3'(r_event);
    assign o_status_now = 2'(r_status);

endmodule
